// ----- rtl/nand_bad_block_bitmap_assert.svh -----
// Assertion macros shared by the checker of the bad block bitmap.
`ifndef NAND_BAD_BLOCK_BITMAP_ASSERT_SVH
`define NAND_BAD_BLOCK_BITMAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nbb_pkg.sv -----
// Types, constants and the control store of the bad block bitmap.
`default_nettype none

package nbb_pkg;

  // Fixed field widths of the request, response and configuration port.
  localparam int PAGE_W  = 32;
  localparam int START_W = 14;
  localparam int CNT_W   = 14;
  localparam int PPB_W   = 13;
  localparam int BC_W    = 16;
  localparam int CFG_IW  = 2;

  // The bitmap is stored as rows of bits.
  localparam int ROW_W  = 32;
  localparam int ROW_LG = 5;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_PPB = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BC  = 2'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_ITER   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [PAGE_W-1:0]    page;
    logic [START_W-1:0]   start_block;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic                 hit;
    logic [PAGE_W-1:0]    found_page;
    logic [START_W-1:0]   next_block;
    logic [CNT_W-1:0]     marked_count;
  } rsp_t;

  // Datapath actions selected by the control word.
  typedef enum logic [3:0] {
    U_NOP,
    U_DIV,
    U_CHK,
    U_LOOK,
    U_MARK,
    U_CLR,
    U_CLR_END,
    U_SRD,
    U_SEV,
    U_MUL,
    U_OUT
  } uop_t;

  // Jump conditions; when false the sequencer steps to the next word.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_WAIT,
    C_IS_CLR,
    C_IS_ITER,
    C_IS_LOOK,
    C_DIV_MORE,
    C_CLR_MORE,
    C_OOR,
    C_SCAN_END,
    C_NOT_FOUND
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_DISP    = 4'd1;
  localparam step_t S_ROUTE   = 4'd2;
  localparam step_t S_DIV     = 4'd3;
  localparam step_t S_CHK     = 4'd4;
  localparam step_t S_LOOK    = 4'd5;
  localparam step_t S_MARK    = 4'd6;
  localparam step_t S_CLR     = 4'd7;
  localparam step_t S_CLR_END = 4'd8;
  localparam step_t S_SCAN_RD = 4'd9;
  localparam step_t S_SCAN_EV = 4'd10;
  localparam step_t S_MUL     = 4'd11;
  localparam step_t S_OUT     = 4'd12;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Status flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic accept;
    logic is_clr;
    logic is_iter;
    logic is_look;
    logic div_more;
    logic clr_more;
    logic oor;
    logic scan_end;
    logic found;
  } flags_t;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      S_IDLE:    w = '{uop: U_NOP,     cond: C_WAIT,      target: S_IDLE};
      S_DISP:    w = '{uop: U_NOP,     cond: C_IS_CLR,    target: S_CLR};
      S_ROUTE:   w = '{uop: U_NOP,     cond: C_IS_ITER,   target: S_SCAN_RD};
      S_DIV:     w = '{uop: U_DIV,     cond: C_DIV_MORE,  target: S_DIV};
      S_CHK:     w = '{uop: U_CHK,     cond: C_OOR,       target: S_OUT};
      S_LOOK:    w = '{uop: U_LOOK,    cond: C_IS_LOOK,   target: S_OUT};
      S_MARK:    w = '{uop: U_MARK,    cond: C_ALWAYS,    target: S_OUT};
      S_CLR:     w = '{uop: U_CLR,     cond: C_CLR_MORE,  target: S_CLR};
      S_CLR_END: w = '{uop: U_CLR_END, cond: C_ALWAYS,    target: S_OUT};
      S_SCAN_RD: w = '{uop: U_SRD,     cond: C_SCAN_END,  target: S_OUT};
      S_SCAN_EV: w = '{uop: U_SEV,     cond: C_NOT_FOUND, target: S_SCAN_RD};
      S_MUL:     w = '{uop: U_MUL,     cond: C_ALWAYS,    target: S_OUT};
      S_OUT:     w = '{uop: U_OUT,     cond: C_ALWAYS,    target: S_IDLE};
      default:   w = '{uop: U_NOP,     cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nbb_seq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none

module nbb_seq
  import nbb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output uop_t        uop,
  output logic        busy
);

  step_t  upc_r;
  step_t  upc_nxt;
  ucode_t word;
  logic   take;

  assign word = ucode_rom(upc_r);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (word.cond)
      C_ALWAYS:    take = 1'b1;
      C_WAIT:      take = !flags.accept;
      C_IS_CLR:    take = flags.is_clr;
      C_IS_ITER:   take = flags.is_iter;
      C_IS_LOOK:   take = flags.is_look;
      C_DIV_MORE:  take = flags.div_more;
      C_CLR_MORE:  take = flags.clr_more;
      C_OOR:       take = flags.oor;
      C_SCAN_END:  take = flags.scan_end;
      C_NOT_FOUND: take = !flags.found;
      default:     take = 1'b1;
    endcase
  end

  // Next step: jump target or fall through.
  always_comb begin
    upc_nxt = take ? word.target : step_t'(upc_r + 4'd1);
  end

  // Outputs toward the datapath.
  always_comb begin
    uop  = word.uop;
    busy = (upc_r != S_IDLE);
  end

  // Reset starts the clearing pass over the bitmap.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nand_bad_block_bitmap.sv -----
// Bad block table for a NAND device: one bad bit per erase block plus a mark count.
//
// Usage: a request (cmd, page, start_block) is taken at a rising edge where
// start is high and busy is low. Exactly one response follows, shown on
// out_rsp for a single cycle while out_valid is high; the receiver cannot
// stall it. The configuration port (cfg_we, cfg_index, cfg_wdata) writes
// the block size in pages (index 0) or the block count (index 1), one
// register per write.
// Steps from the accepting edge to the response strobe:
//   add and lookup run the 32-step restoring divider that maps a page to
//   its block (one quotient bit per cycle);
//   clear writes one 32-bit row of the bitmap per cycle;
//   iterate needs a memory read and an evaluation step for each bitmap row
//   that it visits.
// One request is in flight at a time; busy drops in the cycle of the strobe.
// After reset the block runs a clearing pass over every row of the bitmap
// memory (the needed row count rounded up to a power of two) with busy high
// and no response.
`default_nettype none

module nand_bad_block_bitmap
  import nbb_pkg::*;
#(
  parameter int MAX_BLOCKS = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              in_req,
  output logic                   out_valid,
  output rsp_t                   out_rsp,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [BC_W-1:0]   cfg_wdata
);

  localparam int BW        = $clog2(MAX_BLOCKS + 1);
  localparam int ROWS_NEED = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int RAW       = (ROWS_NEED > 1) ? $clog2(ROWS_NEED) : 1;
  localparam int ROWS      = 2 ** RAW;
  localparam int SCW       = ((BW > START_W) ? BW : START_W) + 1;
  localparam int PW        = BW + PPB_W;

  // Control and sequencing.
  uop_t   uop;
  flags_t flags;
  logic   accept;

  // Configuration registers.
  logic [PPB_W-1:0] ppb_r;
  logic [BC_W-1:0]  bc_r;

  // Request and working registers.
  cmd_t              cmd_r;
  logic [BW-1:0]     usable_r;
  logic [BW-1:0]     usable_nxt;
  logic [PAGE_W-1:0] quo_r;
  logic [PPB_W-1:0]  rem_r;
  logic [4:0]        div_cnt_r;
  logic [RAW-1:0]    clr_ptr_r;
  logic [SCW-1:0]    scan_r;
  logic [BW-1:0]     blk_r;
  logic [BW-1:0]     marked_r;
  logic              init_r;

  // Response fields under construction.
  logic              status_r;
  logic              hit_r;
  logic [PAGE_W-1:0] found_r;
  logic [BW-1:0]     next_r;
  logic              out_valid_r;
  rsp_t              out_rsp_r;

  // Bitmap memory.
  logic [ROW_W-1:0]  bad_map [ROWS];
  logic [ROW_W-1:0]  rd_r;
  logic [RAW-1:0]    mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_wdata;

  // Datapath helpers.
  logic [PPB_W:0]    trial;
  logic              trial_ge;
  logic [ROW_W-1:0]  bit_mask;
  logic              cur_bit;
  logic [SCW-1:0]    scan_base;
  logic [ROW_W-1:0]  lane_hit;
  logic [ROW_LG-1:0] lane_sel;
  logic [SCW-1:0]    lane_blk;
  logic [PW-1:0]     prod;

  nbb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uop   (uop),
    .busy  (busy)
  );

  assign accept = start && !busy;

  // Usable block count; zero when the table is disabled.
  always_comb begin
    if (ppb_r == '0 || 32'(bc_r) > 32'(MAX_BLOCKS)) begin
      usable_nxt = '0;
    end else begin
      usable_nxt = BW'(bc_r);
    end
  end

  // One restoring division step.
  always_comb begin
    trial    = {rem_r, quo_r[PAGE_W-1]};
    trial_ge = (trial >= {1'b0, ppb_r});
  end

  // Bit of the addressed block within its row.
  always_comb begin
    bit_mask = ROW_W'(1) << quo_r[ROW_LG-1:0];
    cur_bit  = rd_r[quo_r[ROW_LG-1:0]];
  end

  // Scan lanes: a set bit at or after the scan position and below the usable count.
  always_comb begin
    scan_base = {scan_r[SCW-1:ROW_LG], {ROW_LG{1'b0}}};
    for (int j = 0; j < ROW_W; j++) begin
      lane_hit[j] = rd_r[j] && (ROW_LG'(j) >= scan_r[ROW_LG-1:0]) &&
                    ((scan_base | SCW'(j)) < SCW'(usable_r));
    end
    lane_sel = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (lane_hit[j]) begin
        lane_sel = ROW_LG'(j);
      end
    end
    lane_blk = scan_base | SCW'(lane_sel);
  end

  assign prod = PW'(blk_r) * PW'(ppb_r);

  // Flags for the jump conditions.
  always_comb begin
    flags.accept   = accept;
    flags.is_clr   = (cmd_r == CMD_CLEAR);
    flags.is_iter  = (cmd_r == CMD_ITER);
    flags.is_look  = (cmd_r == CMD_LOOKUP);
    flags.div_more = (div_cnt_r != 5'd31);
    flags.clr_more = (clr_ptr_r != {RAW{1'b1}});
    flags.oor      = (quo_r >= 32'(usable_r));
    flags.scan_end = (scan_r >= SCW'(usable_r));
    flags.found    = |lane_hit;
  end

  // Memory port control.
  always_comb begin
    case (uop)
      U_CLR:   mem_addr = clr_ptr_r;
      U_SRD:   mem_addr = scan_r[RAW+ROW_LG-1:ROW_LG];
      default: mem_addr = quo_r[RAW+ROW_LG-1:ROW_LG];
    endcase
    mem_we    = (uop == U_CLR) || (uop == U_MARK);
    mem_re    = (uop == U_CHK) || (uop == U_SRD);
    mem_wdata = (uop == U_CLR) ? '0 : (rd_r | bit_mask);
  end

  // Bitmap storage with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bad_map[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= bad_map[mem_addr];
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppb_r <= PPB_W'(64);
      bc_r  <= BC_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PPB: ppb_r <= cfg_wdata[PPB_W-1:0];
        CFG_BC:  bc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control registers: mark count, clear pointer, reset pass flag, strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marked_r    <= '0;
      clr_ptr_r   <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (uop == U_OUT) && !init_r;
      if (accept) begin
        clr_ptr_r <= '0;
      end
      case (uop)
        U_CLR:     clr_ptr_r <= clr_ptr_r + RAW'(1);
        U_CLR_END: marked_r  <= '0;
        U_MARK:    if (!cur_bit) marked_r <= marked_r + BW'(1);
        U_OUT:     init_r    <= 1'b0;
        default:   ;
      endcase
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_req.cmd;
      usable_r  <= usable_nxt;
      quo_r     <= in_req.page;
      rem_r     <= '0;
      div_cnt_r <= '0;
      scan_r    <= SCW'(in_req.start_block);
      status_r  <= 1'b0;
      hit_r     <= 1'b0;
      found_r   <= '0;
      next_r    <= (in_req.cmd == CMD_ITER) ? usable_nxt : '0;
    end else begin
      case (uop)
        U_DIV: begin
          quo_r     <= {quo_r[PAGE_W-2:0], trial_ge};
          rem_r     <= trial_ge ? PPB_W'(trial - {1'b0, ppb_r}) : trial[PPB_W-1:0];
          div_cnt_r <= div_cnt_r + 5'd1;
        end
        U_CHK:  status_r <= flags.oor && (cmd_r == CMD_ADD);
        U_LOOK: hit_r    <= cur_bit && (cmd_r == CMD_LOOKUP);
        U_SEV: begin
          if (flags.found) begin
            hit_r  <= 1'b1;
            blk_r  <= BW'(lane_blk);
            next_r <= BW'(lane_blk + SCW'(1));
          end else begin
            scan_r <= scan_base + SCW'(ROW_W);
          end
        end
        U_MUL:   found_r <= PAGE_W'(prod);
        default: ;
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (uop == U_OUT) begin
      out_rsp_r.status       <= status_r;
      out_rsp_r.hit          <= hit_r;
      out_rsp_r.found_page   <= found_r;
      out_rsp_r.next_block   <= START_W'(next_r);
      out_rsp_r.marked_count <= CNT_W'(marked_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

// ----- rtl/nbb_chk.sv -----
// Port checker for the bad block bitmap and its bind to the top level.
`default_nettype none

`include "nand_bad_block_bitmap_assert.svh"

module nbb_chk
  import nbb_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire rsp_t out_rsp
);

  // A taken request keeps the block busy in the following cycle.
  `NBB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after request")

  // One response per request: the strobe lasts a single cycle.
  `NBB_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "response strobe held")

  // The response appears only once the block has gone idle.
  `NBB_ASSERT_NOW(a_idle_on_resp, out_valid, !busy, "response while busy")

  // A failed add carries no lookup or iterate result.
  `NBB_ASSERT_NOW(a_fail_clean, out_valid && out_rsp.status,
    !out_rsp.hit && out_rsp.found_page == '0 && out_rsp.next_block == '0,
    "failed add with result fields set")

endmodule

bind nand_bad_block_bitmap nbb_chk u_nbb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

`default_nettype wire

// ----- bench/tb_nand_bad_block_bitmap.sv -----
// Self-checking testbench for the NAND bad block bitmap with a shadow table.
module tb_nand_bad_block_bitmap;
  import nbb_pkg::*;

  localparam int MAX_BLOCKS = 8192;

  // Indexes that no register answers to.
  localparam logic [CFG_IW-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SPARE3 = 2'd3;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  req_t              in_req = '0;
  logic              out_valid;
  rsp_t              out_rsp;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_PPB;
  logic [BC_W-1:0]   cfg_wdata = '0;

  // Shadow copy of the table and its registers.
  bit               shadow_map [MAX_BLOCKS];
  logic [CNT_W-1:0] shadow_count = '0;
  logic [PPB_W-1:0] shadow_ppb = 13'd64;
  logic [BC_W-1:0]  shadow_bc = 16'd1024;

  req_t        cmd_backlog [$];
  rsp_t        due_rsps [$];
  int unsigned recent_blks [$];
  int unsigned items_queued = 0;
  int unsigned rsps_seen = 0;
  int unsigned fail_count = 0;
  int unsigned idle_left = 0;
  bit          gaps_on = 1'b1;

  nand_bad_block_bitmap #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Blocks visible to commands under the current registers.
  function automatic int unsigned usable_count();
    if (shadow_ppb == '0 || shadow_bc > MAX_BLOCKS) return 0;
    return 32'(shadow_bc);
  endfunction

  // Applies one request to the shadow table and returns the response it owes.
  function automatic rsp_t table_response(req_t r);
    rsp_t            o;
    int unsigned     usable;
    longint unsigned blk;
    o = '0;
    usable = usable_count();
    blk = (shadow_ppb == '0) ? MAX_BLOCKS : r.page / shadow_ppb;
    case (r.cmd)
      CMD_CLEAR: begin
        shadow_map = '{default: 1'b0};
        shadow_count = '0;
      end
      CMD_ADD: begin
        if (blk >= usable) begin
          o.status = 1'b1;
        end else if (!shadow_map[blk]) begin
          shadow_map[blk] = 1'b1;
          shadow_count++;
        end
      end
      CMD_LOOKUP: begin
        if (blk < usable) o.hit = shadow_map[blk];
      end
      default: begin
        // Scan forward for the first bad block at or after the start.
        o.next_block = usable[CNT_W-1:0];
        for (int unsigned b = r.start_block; b < usable; b++) begin
          if (shadow_map[b]) begin
            o.hit = 1'b1;
            o.found_page = 32'(b * shadow_ppb);
            o.next_block = 14'(b + 1);
            break;
          end
        end
      end
    endcase
    o.marked_count = shadow_count;
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 0;
    if (roll < 80) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 45);
    return $urandom_range(46, 120);
  endfunction

  // Random request aimed mostly at blocks in range and at blocks already marked.
  function automatic req_t random_request();
    req_t        r;
    int unsigned usable;
    int unsigned roll;
    int unsigned blk;
    usable = usable_count();
    roll = $urandom_range(0, 99);
    r.cmd = (roll < 3) ? CMD_CLEAR : (roll < 45) ? CMD_ADD : (roll < 72) ? CMD_LOOKUP : CMD_ITER;
    if (r.cmd == CMD_LOOKUP && recent_blks.size() != 0 && $urandom_range(0, 1) == 1)
      blk = recent_blks[$urandom_range(0, recent_blks.size() - 1)];
    else
      blk = $urandom_range(0, usable + 2);
    case ($urandom_range(0, 9))
      0: r.page = $urandom();
      1: r.page = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: begin
        if (shadow_ppb == '0)
          r.page = $urandom_range(0, 20000);
        else
          r.page = blk * shadow_ppb + $urandom_range(0, shadow_ppb - 1);
      end
    endcase
    if (r.cmd == CMD_ADD && recent_blks.size() < 64) recent_blks.push_back(blk);
    roll = $urandom_range(0, 9);
    if (roll == 0)
      r.start_block = 14'($urandom());
    else if (roll < 6 && recent_blks.size() != 0) begin
      blk = recent_blks[$urandom_range(0, recent_blks.size() - 1)];
      r.start_block = 14'((blk > 3) ? blk - $urandom_range(0, 3) : blk);
    end else
      r.start_block = 14'($urandom_range(0, usable + 2));
    return r;
  endfunction

  task automatic queue_request(cmd_t c, logic [PAGE_W-1:0] pg, logic [START_W-1:0] sb);
    req_t r;
    r.cmd = c;
    r.page = pg;
    r.start_block = sb;
    cmd_backlog.push_back(r);
    items_queued++;
  endtask

  task automatic random_phase(int unsigned n);
    recent_blks.delete();
    repeat (n) begin
      cmd_backlog.push_back(random_request());
      items_queued++;
    end
    settle();
  endtask

  // Waits until every queued request has been answered and the block is idle.
  task automatic settle();
    do @(posedge clk); while (rsps_seen != items_queued || busy);
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [BC_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PPB: shadow_ppb = data[PPB_W-1:0];
      CFG_BC:  shadow_bc = data;
      default: ;
    endcase
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  // Request driver: presents the next pending request and holds it until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        due_rsps.push_back(table_response(in_req));
        idle_left = pick_gap();
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_req <= cmd_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Response monitor: every strobe must match the oldest outstanding response.
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (rst_n && out_valid) begin
      rsps_seen++;
      if (due_rsps.size() == 0) begin
        fail_count++;
        $display("%0t: response with none outstanding, expected none actual %h",
                 $time, out_rsp);
      end else begin
        want = due_rsps.pop_front();
        check_field("status", want.status, out_rsp.status);
        check_field("hit", want.hit, out_rsp.hit);
        check_field("found_page", want.found_page, out_rsp.found_page);
        check_field("next_block", want.next_block, out_rsp.next_block);
        check_field("marked_count", want.marked_count, out_rsp.marked_count);
      end
    end
  end

  // Stimulus: directed corners at each setting, then random traffic.
  initial begin
    shadow_map = '{default: 1'b0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settle();

    // Reset settings: block edges, out of range pages and scan limits.
    queue_request(CMD_LOOKUP, 32'd0, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd0);
    queue_request(CMD_ADD, 32'd0, 14'd0);
    queue_request(CMD_ADD, 32'd63, 14'd0);
    queue_request(CMD_ADD, 32'd64, 14'd0);
    queue_request(CMD_ADD, 32'd65535, 14'h3FFF);
    queue_request(CMD_ADD, 32'd65536, 14'd0);
    queue_request(CMD_ADD, 32'hFFFF_FFFF, 14'd0);
    queue_request(CMD_LOOKUP, 32'd63, 14'd0);
    queue_request(CMD_LOOKUP, 32'd128, 14'd0);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd1);
    queue_request(CMD_ITER, 32'hFFFF_FFFF, 14'd2);
    queue_request(CMD_ITER, 32'd0, 14'd1024);
    queue_request(CMD_ITER, 32'd0, 14'h3FFF);
    queue_request(CMD_CLEAR, 32'hFFFF_FFFF, 14'h3FFF);
    queue_request(CMD_LOOKUP, 32'd0, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd0);
    settle();
    random_phase(200);

    // High bits of the block size are dropped; spare indexes change nothing.
    set_reg(CFG_PPB, 16'hE005);
    set_reg(CFG_BC, 16'd8);
    set_reg(CFG_SPARE2, 16'hFFFF);
    set_reg(CFG_SPARE3, 16'h1234);
    queue_request(CMD_ADD, 32'd39, 14'd0);
    queue_request(CMD_ADD, 32'd40, 14'd0);
    queue_request(CMD_LOOKUP, 32'd39, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd7);
    settle();
    random_phase(150);

    // Full table with one page per block, back to back.
    gaps_on = 1'b0;
    set_reg(CFG_PPB, 16'd1);
    set_reg(CFG_BC, 16'd8192);
    queue_request(CMD_ADD, 32'd8191, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd8191);
    queue_request(CMD_ADD, 32'd8192, 14'd0);
    settle();
    random_phase(250);
    gaps_on = 1'b1;

    // Disabled table: zero block size, then too many blocks.
    set_reg(CFG_PPB, 16'd0);
    random_phase(100);
    set_reg(CFG_PPB, 16'd4096);
    set_reg(CFG_BC, 16'hFFFF);
    random_phase(80);
    set_reg(CFG_PPB, 16'h1FFF);
    set_reg(CFG_BC, 16'd8193);
    random_phase(60);
    set_reg(CFG_BC, 16'd8192);
    random_phase(150);

    // Marks above a shrunken block count stay counted but are hidden.
    set_reg(CFG_PPB, 16'd1);
    queue_request(CMD_ADD, 32'd8000, 14'd0);
    settle();
    set_reg(CFG_BC, 16'd100);
    queue_request(CMD_LOOKUP, 32'd8000, 14'd0);
    queue_request(CMD_ITER, 32'd0, 14'd0);
    settle();
    random_phase(150);

    // No usable blocks at all.
    set_reg(CFG_PPB, 16'd7);
    set_reg(CFG_BC, 16'd0);
    random_phase(60);

    // A few arbitrary geometries, one of them without gaps.
    for (int i = 0; i < 3; i++) begin
      gaps_on = (i != 1);
      set_reg(CFG_PPB, 16'($urandom_range(1, 300)));
      set_reg(CFG_BC, 16'($urandom_range(1, 2048)));
      random_phase(100);
    end
    gaps_on = 1'b1;

    set_reg(CFG_PPB, 16'd64);
    set_reg(CFG_BC, 16'd1024);
    random_phase(100);

    // Let any stray response show up before the verdict.
    repeat (600) @(posedge clk);
    if (fail_count == 0 && due_rsps.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
